// ===== design/chpe_pkg.sv =====
package chpe_pkg;

    // Fixed field widths
    localparam int DATA_W     = 32;
    localparam int COEF_W     = 2 * DATA_W;
    localparam int DEG_W      = 3;
    localparam int NUM_COEFS  = 7;
    localparam int CFG_IDX_W  = 4;

    // Parameter defaults
    localparam int MAX_DEGREE_DEF = 6;
    localparam int FRAC_BITS_DEF  = 16;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_POLY_DEGREE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST   = CFG_IDX_W'(NUM_COEFS);

endpackage

// ===== design/complex_horner_poly_eval.sv =====
// Complex polynomial evaluator, Horner's rule, signed fixed point (Q16.16 by default).
// Channels:
//   cfg   - cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is the degree,
//           indexes 1..7 are coefficients 0..6 (real in bits 63:32, imaginary in 31:0).
//           cfg_ready is always high; write only while no item is in flight.
//   input - in_valid/in_ready with x_real and x_imag.
//   output- out_valid/out_ready with y_real, y_imag and overflow.
// Pipeline: one load stage, then three stages per Horner step (complex multiply,
// round and saturate, coefficient add), MAX_DEGREE steps in all, 1 + 3*MAX_DEGREE
// register stages. Steps above the programmed degree pass zero through, so latency
// does not depend on the degree. One transfer per cycle in each direction when not
// stalled.
// Each stage has its own load enable: when out_ready is low the pipeline keeps
// filling its empty stages, and in_ready drops only once every stage holds an item.
// Reset clears all stage valid bits, the degree and the coefficients.
module complex_horner_poly_eval #(
    parameter int MAX_DEGREE = chpe_pkg::MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = chpe_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [chpe_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [chpe_pkg::COEF_W-1:0]           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [chpe_pkg::DATA_W-1:0]    x_real,
    input  logic signed [chpe_pkg::DATA_W-1:0]    x_imag,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [chpe_pkg::DATA_W-1:0]    y_real,
    output logic signed [chpe_pkg::DATA_W-1:0]    y_imag,
    output logic                                  overflow
);

    localparam int DW     = chpe_pkg::DATA_W;
    localparam int PROD_W = 2 * DW;
    localparam int RND_W  = PROD_W + 2;
    localparam int NSTEP  = MAX_DEGREE;
    localparam int NSTG   = 1 + 3 * NSTEP;

    localparam logic signed [RND_W-1:0] HALF  = RND_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [RND_W-1:0] Q_MAX =
        {{(RND_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [RND_W-1:0] Q_MIN =
        {{(RND_W-DW+1){1'b1}}, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};

    // ---------------- configuration ----------------
    logic [chpe_pkg::DEG_W-1:0]  degree_reg;
    logic [chpe_pkg::COEF_W-1:0] coef_reg [chpe_pkg::NUM_COEFS];
    logic [chpe_pkg::DEG_W-1:0]  deg_eff;
    logic [chpe_pkg::CFG_IDX_W-1:0] coef_sel;

    assign cfg_ready = 1'b1;
    assign coef_sel  = cfg_index - chpe_pkg::REG_COEF_FIRST;
    assign deg_eff   = (degree_reg > chpe_pkg::DEG_W'(MAX_DEGREE))
                     ? chpe_pkg::DEG_W'(MAX_DEGREE) : degree_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= '0;
            for (int n = 0; n < chpe_pkg::NUM_COEFS; n++)
            begin
                coef_reg[n] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == chpe_pkg::REG_POLY_DEGREE)
            begin
                degree_reg <= cfg_data[chpe_pkg::DEG_W-1:0];
            end
            else if (cfg_index >= chpe_pkg::REG_COEF_FIRST &&
                     cfg_index <= chpe_pkg::REG_COEF_LAST)
            begin
                for (int n = 0; n < chpe_pkg::NUM_COEFS; n++)
                begin
                    if (coef_sel == chpe_pkg::CFG_IDX_W'(n))
                    begin
                        coef_reg[n] <= cfg_data;
                    end
                end
            end
        end
    end

    // ---------------- stage control ----------------
    logic v_reg [NSTG];
    logic en    [NSTG];

    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // ---------------- datapath ----------------
    // Index 0 is the load stage, index s+1 the add stage of step s.
    logic signed [DW-1:0] xr_reg  [NSTEP+1];
    logic signed [DW-1:0] xi_reg  [NSTEP+1];
    logic signed [DW-1:0] yr_reg  [NSTEP+1];
    logic signed [DW-1:0] yi_reg  [NSTEP+1];
    logic                 ovf_reg [NSTEP+1];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            xr_reg[0]  <= x_real;
            xi_reg[0]  <= x_imag;
            ovf_reg[0] <= 1'b0;
            if (deg_eff == chpe_pkg::DEG_W'(MAX_DEGREE))
            begin
                yr_reg[0] <= coef_reg[MAX_DEGREE][PROD_W-1:DW];
                yi_reg[0] <= coef_reg[MAX_DEGREE][DW-1:0];
            end
            else
            begin
                yr_reg[0] <= '0;
                yi_reg[0] <= '0;
            end
        end
    end

    for (genvar s = 0; s < NSTEP; s++)
    begin : g_step
        localparam int CI = MAX_DEGREE - 1 - s;
        localparam int SM = 1 + 3 * s;

        logic active;
        logic load_here;

        // multiply stage
        logic signed [PROD_W-1:0] pac_reg, pbd_reg, pad_reg, pbc_reg;
        logic signed [DW-1:0]     xm_r_reg, xm_i_reg;
        logic                     ovf_m_reg;

        // round stage
        logic signed [RND_W-1:0]  re_sum, im_sum, re_q, im_q;
        logic signed [DW-1:0]     mr_next, mi_next;
        logic                     rnd_ovf;
        logic signed [DW-1:0]     mr_reg, mi_reg, xq_r_reg, xq_i_reg;
        logic                     ovf_q_reg;

        // add stage
        logic signed [DW:0]       ar_sum, ai_sum;
        logic signed [DW-1:0]     cr, ci;
        logic signed [DW-1:0]     yr_next, yi_next;
        logic                     ovf_next;

        assign active    = deg_eff > chpe_pkg::DEG_W'(CI);
        assign load_here = deg_eff == chpe_pkg::DEG_W'(CI);

        always_ff @(posedge clk)
        begin
            if (en[SM])
            begin
                pac_reg   <= yr_reg[s] * xr_reg[s];
                pbd_reg   <= yi_reg[s] * xi_reg[s];
                pad_reg   <= yr_reg[s] * xi_reg[s];
                pbc_reg   <= yi_reg[s] * xr_reg[s];
                xm_r_reg  <= xr_reg[s];
                xm_i_reg  <= xi_reg[s];
                ovf_m_reg <= ovf_reg[s];
            end
        end

        // exact combine, round half up, saturate
        always_comb
        begin
            re_sum  = RND_W'(pac_reg) - RND_W'(pbd_reg) + HALF;
            im_sum  = RND_W'(pad_reg) + RND_W'(pbc_reg) + HALF;
            re_q    = re_sum >>> FRAC_BITS;
            im_q    = im_sum >>> FRAC_BITS;
            rnd_ovf = 1'b0;
            mr_next = re_q[DW-1:0];
            mi_next = im_q[DW-1:0];
            if (re_q > Q_MAX)
            begin
                mr_next = S_MAX;
                rnd_ovf = 1'b1;
            end
            else if (re_q < Q_MIN)
            begin
                mr_next = S_MIN;
                rnd_ovf = 1'b1;
            end
            if (im_q > Q_MAX)
            begin
                mi_next = S_MAX;
                rnd_ovf = 1'b1;
            end
            else if (im_q < Q_MIN)
            begin
                mi_next = S_MIN;
                rnd_ovf = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[SM+1])
            begin
                mr_reg    <= mr_next;
                mi_reg    <= mi_next;
                xq_r_reg  <= xm_r_reg;
                xq_i_reg  <= xm_i_reg;
                ovf_q_reg <= ovf_m_reg || (rnd_ovf && active);
            end
        end

        // coefficient add; steps above the degree hold zero, the top one loads
        always_comb
        begin
            cr       = coef_reg[CI][PROD_W-1:DW];
            ci       = coef_reg[CI][DW-1:0];
            ar_sum   = (DW+1)'(mr_reg) + (DW+1)'(cr);
            ai_sum   = (DW+1)'(mi_reg) + (DW+1)'(ci);
            ovf_next = ovf_q_reg;
            yr_next  = ar_sum[DW-1:0];
            yi_next  = ai_sum[DW-1:0];
            if (ar_sum[DW] != ar_sum[DW-1])
            begin
                yr_next  = ar_sum[DW] ? S_MIN : S_MAX;
                ovf_next = 1'b1;
            end
            if (ai_sum[DW] != ai_sum[DW-1])
            begin
                yi_next  = ai_sum[DW] ? S_MIN : S_MAX;
                ovf_next = 1'b1;
            end
            if (load_here)
            begin
                yr_next  = cr;
                yi_next  = ci;
                ovf_next = ovf_q_reg;
            end
            else if (!active)
            begin
                yr_next  = '0;
                yi_next  = '0;
                ovf_next = ovf_q_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[SM+2])
            begin
                yr_reg[s+1]  <= yr_next;
                yi_reg[s+1]  <= yi_next;
                xr_reg[s+1]  <= xq_r_reg;
                xi_reg[s+1]  <= xq_i_reg;
                ovf_reg[s+1] <= ovf_next;
            end
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign y_real    = yr_reg[NSTEP];
    assign y_imag    = yi_reg[NSTEP];
    assign overflow  = ovf_reg[NSTEP];

endmodule

// ===== test/complex_horner_poly_eval_test.sv =====
module complex_horner_poly_eval_test;

    timeunit 1ns;
    timeprecision 1ps;

    import chpe_pkg::*;

    localparam int     MAX_DEG       = MAX_DEGREE_DEF;
    localparam int     FRAC          = FRAC_BITS_DEF;
    localparam int     LATENCY       = 1 + 3 * MAX_DEG;
    localparam int     NUM_PHASES    = 10;
    localparam int     PHASE_ITEMS   = 100;
    localparam int     STALL_LIMIT   = 5000;
    localparam int     COEF_IDX_W    = $clog2(NUM_COEFS);
    localparam longint S32_MAX       = 64'sh7FFF_FFFF;
    localparam longint S32_MIN       = -64'sh8000_0000;
    localparam longint FRAC_MASK     = (64'sd1 <<< FRAC) - 64'sd1;
    localparam longint HALF_LSB      = 64'sd1 <<< (FRAC - 1);
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP = '1;

    typedef struct packed {
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic              ovf;
    } poly_out_t;

    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] index;
        logic [COEF_W-1:0]    data;
        logic [DATA_W-1:0]    xr;
        logic [DATA_W-1:0]    xi;
        bit                   typed;
        poly_out_t            y;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [COEF_W-1:0]        cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [DATA_W-1:0] x_real;
    logic signed [DATA_W-1:0] x_imag;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] y_real;
    logic signed [DATA_W-1:0] y_imag;
    logic                     overflow;

    // shadow of the register file
    logic [DEG_W-1:0]  degree_reg;
    logic [COEF_W-1:0] coef_reg [NUM_COEFS];

    poly_out_t y_expected [$];
    stim_row_t stim_rows [$];
    int        mismatches;
    int        stall_cycles;
    bit        no_gaps;

    complex_horner_poly_eval u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x_real    (x_real),
        .x_imag    (x_imag),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .y_real    (y_real),
        .y_imag    (y_imag),
        .overflow  (overflow)
    );

    function automatic longint clamp32(input longint v, inout bit sat);
        if (v > S32_MAX)
        begin
            sat = 1'b1;
            return S32_MAX;
        end
        if (v < S32_MIN)
        begin
            sat = 1'b1;
            return S32_MIN;
        end
        return v;
    endfunction

    // (p1 +/- p2) rounded half up; products are split so the sum never wraps
    function automatic longint round_q(input longint p1, input longint p2,
                                       input bit subtract, inout bit sat);
        longint q1, q2, r1, r2, t;
        q1 = p1 >>> FRAC;
        r1 = p1 & FRAC_MASK;
        q2 = p2 >>> FRAC;
        r2 = p2 & FRAC_MASK;
        if (subtract)
        begin
            q2 = -q2;
            r2 = -r2;
        end
        t = r1 + r2 + HALF_LSB;
        return clamp32(q1 + q2 + (t >>> FRAC), sat);
    endfunction

    function automatic poly_out_t eval_horner(input logic [DATA_W-1:0] xr,
                                              input logic [DATA_W-1:0] xi);
        longint    ar, ai, yr, yi, mr, mi;
        bit        sat;
        int        top, i;
        poly_out_t y;
        ar  = longint'($signed(xr));
        ai  = longint'($signed(xi));
        sat = 1'b0;
        top = (degree_reg > MAX_DEG) ? MAX_DEG : int'(degree_reg);
        yr  = longint'($signed(coef_reg[top][COEF_W-1:DATA_W]));
        yi  = longint'($signed(coef_reg[top][DATA_W-1:0]));
        for (i = top - 1; i >= 0; i--)
        begin
            mr = round_q(yr * ar, yi * ai, 1'b1, sat);
            mi = round_q(yr * ai, yi * ar, 1'b0, sat);
            yr = clamp32(mr + longint'($signed(coef_reg[i][COEF_W-1:DATA_W])), sat);
            yi = clamp32(mi + longint'($signed(coef_reg[i][DATA_W-1:0])), sat);
        end
        y.re  = yr[DATA_W-1:0];
        y.im  = yi[DATA_W-1:0];
        y.ovf = sat;
        return y;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DATA_W-1:0] near_zero(input int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span;
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] corner_value();
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    // mostly within +/-2.0 so deep polynomials do not just sit at the rails
    function automatic logic [DATA_W-1:0] rand_point();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return corner_value();
        if (r < 5)
            return $urandom;
        if (r < 12)
            return near_zero(1 << (FRAC + 1));
        return near_zero(1 << FRAC);
    endfunction

    function automatic logic [DATA_W-1:0] rand_coef_part();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return $urandom;
        if (r == 2)
            return corner_value();
        if (r < 10)
            return near_zero(1 << (FRAC + 2));
        return near_zero(1 << FRAC);
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [COEF_W-1:0] data);
        if (idx == REG_POLY_DEGREE)
            degree_reg = data[DEG_W-1:0];
        else if (idx >= REG_COEF_FIRST && idx <= REG_COEF_LAST)
            coef_reg[COEF_IDX_W'(idx - REG_COEF_FIRST)] = data;
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [COEF_W-1:0] data);
        stim_row_t row;
        row = '{default: '0};
        row.is_reg = 1'b1;
        row.index  = idx;
        row.data   = data;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_point(input logic [DATA_W-1:0] xr,
                                      input logic [DATA_W-1:0] xi,
                                      input bit typed, input poly_out_t y);
        stim_row_t row;
        row = '{default: '0};
        row.xr    = xr;
        row.xi    = xi;
        row.typed = typed;
        row.y     = y;
        stim_rows.push_back(row);
    endfunction

    // drop valid and hold off until every result is back
    task automatic wait_idle();
        if (in_valid)
            in_valid <= 1'b0;
        while (y_expected.size() != 0)
            @(posedge clk);
    endtask

    // leaves cfg_valid high so back-to-back writes follow one another without a gap
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [COEF_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, data);
    endtask

    task automatic send_point(input logic [DATA_W-1:0] xr, input logic [DATA_W-1:0] xi,
                              input bit typed, input poly_out_t y);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        x_real   <= xr;
        x_imag   <= xi;
        do
            @(posedge clk);
        while (!in_ready);
        y_expected.push_back(typed ? y : eval_horner(xr, xi));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(30, 150)) @(posedge clk);
            else
            begin
                int gap;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        poly_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (y_expected.size() == 0)
            begin
                $display("%0t unexpected result: expected none, got %h %h %b",
                         $time, y_real, y_imag, overflow);
                mismatches++;
            end
            else
            begin
                want = y_expected.pop_front();
                if (y_real !== want.re)
                begin
                    $display("%0t y_real mismatch: expected %h, got %h",
                             $time, want.re, y_real);
                    mismatches++;
                end
                if (y_imag !== want.im)
                begin
                    $display("%0t y_imag mismatch: expected %h, got %h",
                             $time, want.im, y_imag);
                    mismatches++;
                end
                if (overflow !== want.ovf)
                begin
                    $display("%0t overflow mismatch: expected %b, got %b",
                             $time, want.ovf, overflow);
                    mismatches++;
                end
            end
        end
    end

    // counts cycles without any transfer on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL complex_horner_poly_eval");
            $finish;
        end
    end

    initial
    begin
        int                p, n, k;
        bit                prev_reg;
        stim_row_t         row;
        logic [COEF_W-1:0] word;

        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        x_real       = '0;
        x_imag       = '0;
        mismatches   = 0;
        stall_cycles = 0;
        no_gaps      = 1'b0;
        degree_reg   = '0;
        for (k = 0; k < NUM_COEFS; k++)
            coef_reg[k] = '0;

        // straight after reset every coefficient is zero
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '0);
        add_point(32'h0000_0000, 32'h0000_0000, 1'b1, '0);
        // degree zero returns the constant term untouched
        add_reg(REG_COEF_FIRST, 64'h7FFF_FFFF_8000_0000);
        add_point(32'h1234_5678, 32'h8765_4321, 1'b1, {32'h7FFF_FFFF, 32'h8000_0000, 1'b0});
        // linear with unit slope: add saturation at both rails
        add_reg(REG_POLY_DEGREE, 64'd1);
        add_reg(CFG_IDX_W'(REG_COEF_FIRST + 1), 64'h0001_0000_0000_0000);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, {32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1});
        add_point(32'h0000_0000, 32'h0000_0000, 1'b1, {32'h7FFF_FFFF, 32'h8000_0000, 1'b0});
        add_point(32'h8000_0000, 32'h8000_0000, 1'b1, {32'hFFFF_FFFF, 32'h8000_0000, 1'b1});
        // one-LSB slope: exact half ties round upward
        add_reg(REG_COEF_FIRST, 64'd0);
        add_reg(CFG_IDX_W'(REG_COEF_FIRST + 1), 64'h0000_0001_0000_0000);
        add_point(32'h0000_8000, 32'h0000_0000, 1'b1, {32'h0000_0001, 32'h0000_0000, 1'b0});
        add_point(32'hFFFF_8000, 32'h0000_0000, 1'b1, '0);
        add_point(32'h0000_7FFF, 32'hFFFF_8001, 1'b0, '0);
        // degree 7 clamps to the sixth power
        add_reg(CFG_IDX_W'(REG_COEF_FIRST + 1), 64'd0);
        add_reg(REG_COEF_LAST, 64'h0001_0000_0000_0000);
        add_reg(REG_POLY_DEGREE, 64'd7);
        add_point(32'h0002_0000, 32'h0000_0000, 1'b1, {32'h0040_0000, 32'h0000_0000, 1'b0});
        add_point(32'h0000_0000, 32'h0001_0000, 1'b1, {32'hFFFF_0000, 32'h0000_0000, 1'b0});
        // multiply saturation part way up the chain, sticky to the end
        add_reg(REG_POLY_DEGREE, 64'd6);
        add_point(32'h0010_0000, 32'h0000_0000, 1'b1, {32'h7FFF_FFFF, 32'h0000_0000, 1'b1});
        // writes to unmapped indexes must leave the register file alone
        add_reg(CFG_IDX_W'(REG_COEF_LAST + 1), '1);
        add_reg(REG_INDEX_TOP, {$urandom, $urandom});
        add_point(32'h0001_0000, 32'h0001_0000, 1'b0, '0);
        add_reg(REG_POLY_DEGREE, 64'd3);
        for (k = 0; k < 4; k++)
            add_reg(CFG_IDX_W'(REG_COEF_FIRST + k), {rand_coef_part(), rand_coef_part()});
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0);
        for (k = 0; k < 4; k++)
            add_point(rand_point(), rand_point(), 1'b0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        prev_reg = 1'b0;
        foreach (stim_rows[k])
        begin
            row = stim_rows[k];
            if (row.is_reg)
            begin
                if (!prev_reg)
                    wait_idle();
                write_reg(row.index, row.data);
            end
            else
                send_point(row.xr, row.xi, row.typed, row.y);
            prev_reg = row.is_reg;
        end

        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            word = {$urandom, $urandom};
            case (p)
                0:       word[DEG_W-1:0] = DEG_W'(MAX_DEG);
                1:       word[DEG_W-1:0] = '1;
                2:       word[DEG_W-1:0] = '0;
                default: word[DEG_W-1:0] = DEG_W'($urandom_range(0, 7));
            endcase
            write_reg(REG_POLY_DEGREE, word);
            for (k = 0; k < NUM_COEFS; k++)
            begin
                case (p)
                    0:       word = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
                    1:       word = {32'h8000_0000, 32'h8000_0000};
                    default: word = {rand_coef_part(), rand_coef_part()};
                endcase
                write_reg(CFG_IDX_W'(REG_COEF_FIRST + k), word);
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_COEF_LAST + 1, REG_INDEX_TOP)),
                          {$urandom, $urandom});

            no_gaps = (p % 4 == 3);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) == 0)
                    wait_idle();
                send_point(rand_point(), rand_point(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (LATENCY + 20) @(posedge clk);
        if (mismatches == 0)
            $display("PASS complex_horner_poly_eval");
        else
            $display("FAIL complex_horner_poly_eval");
        $finish;
    end

endmodule
